>>> design/cfrv_pkg.sv
// Shared constants, types and character-class functions of the colon-field
// response validator. No dependencies; used by every module of the block.
`default_nettype none

package cfrv_pkg;

  // Field sizes and limits.
  localparam logic [12:0] OFFSET_SAT  = 13'd8191;
  localparam logic [12:0] HEAD_LEN    = 13'd7;
  localparam logic [12:0] KIND_LEN    = 13'd4;
  localparam logic [12:0] LONG_FIELD  = 13'd42;
  localparam logic [12:0] SHORT_FIELD = 13'd10;
  localparam logic [12:0] MAX_BYTES_RESET = 13'd1024;
  localparam logic [3:0]  FIELD_COUNT = 4'd8;

  // Special characters.
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_SEP  = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_X    = 8'h78;  // 'x'

  // Field numbers within a reply.
  localparam logic [3:0] FIELD_HEAD   = 4'd0;
  localparam logic [3:0] FIELD_NAME   = 4'd1;
  localparam logic [3:0] FIELD_HASH_A = 4'd2;
  localparam logic [3:0] FIELD_KIND   = 4'd3;
  localparam logic [3:0] FIELD_HASH_B = 4'd4;
  localparam logic [3:0] FIELD_SHORT  = 4'd5;
  localparam logic [3:0] FIELD_HASH_C = 4'd6;
  localparam logic [3:0] FIELD_ECHO   = 4'd7;

  // Name store access from the parser.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_addr;
  } name_req_t;

  // Expected text of the first field, "SNRESPS".
  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h53;
      3'd1: ch = 8'h4E;
      3'd2: ch = 8'h52;
      3'd3: ch = 8'h45;
      3'd4: ch = 8'h53;
      3'd5: ch = 8'h50;
      3'd6: ch = 8'h53;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected text of the fourth field, "xsvr".
  function automatic logic [7:0] kind_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h78;
      2'd1: ch = 8'h73;
      2'd2: ch = 8'h76;
      default: ch = 8'h72;
    endcase
    return ch;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h2D || c == 8'h5F;
  endfunction

  function automatic logic is_hex(input logic [7:0] c, input logic lower);
    logic digit;
    logic letter;
    digit  = (c >= 8'h30 && c <= 8'h39);
    letter = lower ? (c >= 8'h61 && c <= 8'h66) : (c >= 8'h41 && c <= 8'h46);
    return digit || letter;
  endfunction

endpackage

`default_nettype wire

>>> design/cfrv_name_ram.sv
// Name store of the validator: one write port, one registered read port.
// Depends on cfrv_pkg for the request struct.
`default_nettype none

module cfrv_name_ram #(
  parameter int DEPTH = 255
) (
  input  wire logic               clk,
  input  wire cfrv_pkg::name_req_t req,
  output logic [7:0]              rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr[AW-1:0]];
  end

endmodule

`default_nettype wire

>>> design/cfrv_parser.sv
// Per-byte parser of the validator: message state, field checks and verdict.
// Depends on cfrv_pkg; reads the name store through cfrv_name_ram.
`default_nettype none

module cfrv_parser #(
  parameter int NAME_MAX_BYTES = 255
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last,
  input  wire logic [12:0]        max_message_bytes,
  input  wire logic [7:0]         name_rd_data,
  output cfrv_pkg::name_req_t     name_req,
  output logic                    accepted
);

  localparam logic [12:0] NAME_MAX = 13'(NAME_MAX_BYTES);

  logic [12:0] bytes_seen, bytes_seen_next;
  logic [3:0]  field_number, field_number_next;
  logic [12:0] field_offset, field_offset_next;
  logic        reject_flag, reject_flag_next;
  logic [7:0]  name_length, name_length_next;

  logic        too_long, nul_bad, is_sep, sep_bad, close_ok, fits_ok;
  logic        reject_total, name_wr;
  logic [3:0]  field_after;
  logic [12:0] offset_after;

  always_comb begin
    too_long = bytes_seen >= max_message_bytes;
    nul_bad  = last ? (data_byte != cfrv_pkg::CHAR_NUL) : (data_byte == cfrv_pkg::CHAR_NUL);
    is_sep   = (data_byte == cfrv_pkg::CHAR_SEP) || last;
    sep_bad  = (field_number >= cfrv_pkg::FIELD_COUNT) || (field_offset == 13'd0);

    // Length check of the field being closed.
    case (field_number)
      cfrv_pkg::FIELD_HEAD:   close_ok = field_offset == cfrv_pkg::HEAD_LEN;
      cfrv_pkg::FIELD_NAME:   close_ok = field_offset <= NAME_MAX;
      cfrv_pkg::FIELD_KIND:   close_ok = field_offset == cfrv_pkg::KIND_LEN;
      cfrv_pkg::FIELD_SHORT:  close_ok = field_offset == cfrv_pkg::SHORT_FIELD;
      cfrv_pkg::FIELD_HASH_A,
      cfrv_pkg::FIELD_HASH_B,
      cfrv_pkg::FIELD_HASH_C: close_ok = field_offset == cfrv_pkg::LONG_FIELD;
      cfrv_pkg::FIELD_ECHO:   close_ok = field_offset == {5'd0, name_length};
      default:                close_ok = 1'b0;
    endcase

    // Content check of a byte inside a field.
    case (field_number)
      cfrv_pkg::FIELD_HEAD:
        fits_ok = (field_offset < cfrv_pkg::HEAD_LEN) &&
                  (data_byte == cfrv_pkg::head_char(field_offset[2:0]));
      cfrv_pkg::FIELD_NAME:
        fits_ok = (field_offset < NAME_MAX) && cfrv_pkg::is_name_char(data_byte);
      cfrv_pkg::FIELD_KIND:
        fits_ok = (field_offset < cfrv_pkg::KIND_LEN) &&
                  (data_byte == cfrv_pkg::kind_char(field_offset[1:0]));
      cfrv_pkg::FIELD_HASH_A,
      cfrv_pkg::FIELD_HASH_B,
      cfrv_pkg::FIELD_SHORT,
      cfrv_pkg::FIELD_HASH_C: begin
        if (field_offset >= ((field_number == cfrv_pkg::FIELD_SHORT) ?
                             cfrv_pkg::SHORT_FIELD : cfrv_pkg::LONG_FIELD)) begin
          fits_ok = 1'b0;
        end else if (field_offset == 13'd0) begin
          fits_ok = data_byte == cfrv_pkg::CHAR_ZERO;
        end else if (field_offset == 13'd1) begin
          fits_ok = data_byte == cfrv_pkg::CHAR_X;
        end else begin
          fits_ok = cfrv_pkg::is_hex(data_byte, field_number == cfrv_pkg::FIELD_SHORT);
        end
      end
      cfrv_pkg::FIELD_ECHO:
        // The store was read at this offset when the previous byte went in.
        fits_ok = (field_offset < {5'd0, name_length}) && (field_offset < NAME_MAX) &&
                  (data_byte == name_rd_data);
      default:
        fits_ok = 1'b0;
    endcase

    name_wr = !is_sep && (field_number == cfrv_pkg::FIELD_NAME) &&
              (field_offset < NAME_MAX) && cfrv_pkg::is_name_char(data_byte);

    field_after  = (is_sep && !sep_bad) ? field_number + 4'd1 : field_number;
    offset_after = is_sep ? 13'd0 :
                   ((field_offset != cfrv_pkg::OFFSET_SAT) ? field_offset + 13'd1
                                                          : field_offset);

    reject_total = reject_flag || too_long || nul_bad ||
                   (is_sep ? (sep_bad || !close_ok) : !fits_ok);
    accepted     = !reject_total && (field_after == cfrv_pkg::FIELD_COUNT);

    bytes_seen_next   = bytes_seen;
    field_number_next = field_number;
    field_offset_next = field_offset;
    reject_flag_next  = reject_flag;
    name_length_next  = name_length;
    if (fire) begin
      if (last) begin
        bytes_seen_next   = 13'd0;
        field_number_next = 4'd0;
        field_offset_next = 13'd0;
        reject_flag_next  = 1'b0;
        name_length_next  = 8'd0;
      end else begin
        bytes_seen_next   = too_long ? bytes_seen : bytes_seen + 13'd1;
        field_number_next = field_after;
        field_offset_next = offset_after;
        reject_flag_next  = reject_total;
        if (is_sep && !sep_bad && field_number == cfrv_pkg::FIELD_NAME && close_ok) begin
          name_length_next = field_offset[7:0];
        end
      end
    end

    name_req.wr_en   = fire && name_wr;
    name_req.wr_addr = field_offset[7:0];
    name_req.wr_data = data_byte;
    // Read ahead at the offset the next byte will see.
    name_req.rd_addr = field_offset_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= 13'd0;
      field_number <= 4'd0;
      field_offset <= 13'd0;
      reject_flag  <= 1'b0;
      name_length  <= 8'd0;
    end else begin
      bytes_seen   <= bytes_seen_next;
      field_number <= field_number_next;
      field_offset <= field_offset_next;
      reject_flag  <= reject_flag_next;
      name_length  <= name_length_next;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && last |=> bytes_seen == 13'd0 && field_number == 4'd0 &&
                     field_offset == 13'd0 && !reject_flag && name_length == 8'd0)
    else $error("parser state not cleared after the last byte");

  a_field_bound: assert property (@(posedge clk) disable iff (rst)
    field_number <= cfrv_pkg::FIELD_COUNT)
    else $error("field number ran past the field count");

  a_name_write_only_in_name: assert property (@(posedge clk) disable iff (rst)
    name_req.wr_en |-> field_number == cfrv_pkg::FIELD_NAME && !last)
    else $error("name store written outside the name field");
`endif

endmodule

`default_nettype wire

>>> design/colon_field_response_validator_unit.sv
// Top level of the colon-field response validator: stream ports, the
// configuration register and the verdict register. Depends on cfrv_pkg,
// cfrv_parser and cfrv_name_ram.
//
// Usage: reply bytes enter on the slave stream (s_tdata holds one byte,
// s_tlast marks the final byte of the reply). Every byte is checked as it
// is taken; only the byte marked last produces an item on the master stream,
// whose bit 0 is 1 when the whole reply matched the expected format.
// The verdict is registered and shown in the cycle after the last byte
// is taken. Throughput: one byte per cycle while s_tready is high; the
// parser checks each byte against its field in a single pass and the name
// store is read one byte ahead, so the field repeating the name never waits.
// Stalls: the verdict sits in an output register; while it waits and the
// receiver holds m_tready low, s_tready is low. A held verdict leaves the
// input side open again in the cycle it is taken.
// Reset (rst, synchronous): clears all parsing state, empties the output
// register and sets max_message_bytes to 1024. The name store holds no reset
// value; it is always written before it is read within a reply.
// Configuration: cfg_wr_en writes cfg_wr_data into max_message_bytes; write
// it only while no reply is in progress.
`default_nettype none

module colon_field_response_validator_unit #(
  parameter int NAME_MAX_BYTES = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration register max_message_bytes.
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  // Reply bytes in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last
  // Verdicts out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // [0] accepted, [7:1] zero
);

  logic [12:0]         max_bytes;
  logic                fire;
  logic                verdict;
  logic                accepted_q;
  logic [7:0]          name_rd_data;
  cfrv_pkg::name_req_t name_req;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, accepted_q};

  // Longest acceptable reply, terminator included.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= cfrv_pkg::MAX_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_bytes <= cfg_wr_data;
    end
  end

  cfrv_parser #(
    .NAME_MAX_BYTES(NAME_MAX_BYTES)
  ) u_parser (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .data_byte         (s_tdata),
    .last              (s_tlast),
    .max_message_bytes (max_bytes),
    .name_rd_data      (name_rd_data),
    .name_req          (name_req),
    .accepted          (verdict)
  );

  cfrv_name_ram #(
    .DEPTH(NAME_MAX_BYTES)
  ) u_name_ram (
    .clk     (clk),
    .req     (name_req),
    .rd_data (name_rd_data)
  );

  // Output register: loaded by the last byte of a reply, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s_tlast) begin
      accepted_q <= verdict;
    end
  end

`ifndef ASSERT_OFF
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    fire && s_tlast |=> m_tvalid)
    else $error("last byte taken without a verdict");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire && s_tlast))
    else $error("verdict appeared without a last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !fire)
    else $error("byte taken while a verdict is stalled");
`endif

endmodule

`default_nettype wire
